### hdl/wsht_pkg.sv
`default_nettype none
package wsht_pkg;

  localparam int unsigned MaxWindowsDef = 16;
  localparam int unsigned CoordBitsDef  = 16;
  localparam int unsigned SizeBits      = 12;
  localparam int unsigned InBits        = 16;
  localparam logic [7:0]  TitleResetVal = 8'd18;
  localparam logic [SizeBits-1:0] SizeMax = 12'd4095;

  // action codes
  localparam logic [2:0] ActCreate = 3'd0;
  localparam logic [2:0] ActFocus  = 3'd1;
  localparam logic [2:0] ActMove   = 3'd2;
  localparam logic [2:0] ActResize = 3'd3;
  localparam logic [2:0] ActClick  = 3'd4;

  // status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  // members listed from the top bit down; status sits in the lowest bits
  typedef struct packed {
    logic [4:0]  focused_id;
    logic [12:0] canvas_y;
    logic [12:0] canvas_x;
    logic        on_right_edge;
    logic        on_left_edge;
    logic        on_bottom_edge;
    logic        on_top_edge;
    logic        on_title_bar;
    logic [4:0]  hit_id;
    logic [1:0]  status;
  } result_t;

  // members listed from the top bit down; action sits in the lowest bits
  typedef struct packed {
    logic [11:0] size_h;
    logic [11:0] size_w;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
    logic [3:0]  window_id;
    logic [2:0]  action;
  } request_t;

endpackage
`default_nettype wire

### hdl/wsht_hit_unit.sv
`default_nettype none
// Frame hit test of one window against a click point; combinational, shared
// by every step of the click walk.
module wsht_hit_unit #(
  parameter int unsigned CoordBits = wsht_pkg::CoordBitsDef
) (
  input  wire logic [CoordBits-1:0] left_i,
  input  wire logic [CoordBits-1:0] top_i,
  input  wire logic [11:0]          width_i,
  input  wire logic [11:0]          height_i,
  input  wire logic [15:0]          px_i,
  input  wire logic [15:0]          py_i,
  input  wire logic [7:0]           tb_i,
  output      logic                 hit_o,
  output      logic [4:0]           flags_o,  // title, top, bottom, left, right
  output      logic                 canvas_o,
  output      logic [12:0]          cx_o,
  output      logic [12:0]          cy_o
);
  import wsht_pkg::*;

  localparam int unsigned W = ((CoordBits > InBits) ? CoordBits : InBits) + 3;

  logic signed [W-1:0] dx, dy, w, h, tb;

  always_comb begin
    dx = W'(signed'(px_i)) - W'(signed'(left_i));
    dy = W'(signed'(py_i)) - W'(signed'(top_i));
    w  = W'({1'b0, width_i});
    h  = W'({1'b0, height_i});
    tb = W'({1'b0, tb_i});
    hit_o = (dx >= 0) && (dx < w + 2) && (dy >= 0) && (dy < h + 1 + tb);
    flags_o[4] = (dy < tb) && (dy > 0) && (dx > 0) && (dx < w);
    flags_o[3] = (dy == 0);
    flags_o[2] = (dy != 0) && (dy == h + tb);
    flags_o[1] = (dx == 0);
    flags_o[0] = (dx != 0) && (dx == w + 1);
    canvas_o = (flags_o == 5'd0);
    cx_o = 13'(dx - 1);
    cy_o = 13'(dy - tb);
  end

endmodule
`default_nettype wire

### hdl/window_stack_hit_test.sv
`default_nettype none
// Sequence: an accepted word runs the stack walk in StScan, then StShift for a
// focus that finds its window, then StDone, then StOut, where the result enters
// the output register. The table holds at most 16 windows. The block goes back
// to StIdle before it takes the next word.
// Throughput: one word at a time; the stack walk steps one entry per cycle
// through a single shared compare/hit unit; a waiting result only holds back
// the hand-off of the next one. Reset (async, active low): empty table,
// focus -1, title height 18, output register empty; table itself not cleared.
module window_stack_hit_test #(
  parameter int unsigned COORD_BITS  = wsht_pkg::CoordBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,       // title_bar_height
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // action[2:0], window_id[6:3], pos_x[22:7], pos_y[38:23],
  // size_w[50:39], size_h[62:51], zero pad [63]
  input  wire logic [63:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[1:0], hit_id[6:2], on_title_bar[7], on_top_edge[8],
  // on_bottom_edge[9], on_left_edge[10], on_right_edge[11],
  // canvas_x[24:12], canvas_y[37:25], focused_id[42:38], zero pad [47:43]
  output      logic [47:0] m_axis_tdata
);
  import wsht_pkg::*;

  localparam int unsigned MAX_WINDOWS = MaxWindowsDef;
  localparam int unsigned IdxW = $clog2(MAX_WINDOWS);
  localparam int unsigned CntW = $clog2(MAX_WINDOWS + 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StShift = 3'd2;
  localparam logic [2:0] StDone  = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  // window table memories, indexed by slot; order_mem is indexed by stack position and holds slots
  logic [3:0]            ident_mem  [MAX_WINDOWS];
  logic [COORD_BITS-1:0] left_mem   [MAX_WINDOWS];
  logic [COORD_BITS-1:0] top_mem    [MAX_WINDOWS];
  logic [11:0]           width_mem  [MAX_WINDOWS];
  logic [11:0]           height_mem [MAX_WINDOWS];
  logic [IdxW-1:0]       order_mem  [MAX_WINDOWS];

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q;
  logic [4:0]      focus_q, focus_d;
  logic [7:0]      tb_q;
  request_t        req_q;
  request_t        in_req;
  logic [CntW-1:0] pos_q;
  logic [3:0]      newid_q;
  logic            found_q;
  logic [CntW-1:0] fpos_q;
  logic [IdxW-1:0] fslot_q;
  logic            out_valid_q;
  result_t         res_q, res_d;
  result_t         out_q;
  logic [IdxW-1:0] walk_idx;
  logic [IdxW-1:0] walk_slot;
  logic [IdxW-1:0] cur_slot;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q};
  assign in_req        = request_t'(s_axis_tdata[62:0]);

  // combinational read of the order entry at the walk position; the click
  // walk runs top down with pos_q one above the entry under test
  assign walk_idx  = (req_q.action == ActClick) ? IdxW'(pos_q - 1'b1) : pos_q[IdxW-1:0];
  assign walk_slot = order_mem[walk_idx];
  assign cur_slot  = walk_slot;

  logic        hu_hit, hu_canvas;
  logic [4:0]  hu_flags;
  logic [12:0] hu_cx, hu_cy;

  wsht_hit_unit #(.CoordBits(COORD_BITS)) u_hit (
    .left_i   (left_mem[cur_slot]),
    .top_i    (top_mem[cur_slot]),
    .width_i  (width_mem[cur_slot]),
    .height_i (height_mem[cur_slot]),
    .px_i     (req_q.pos_x),
    .py_i     (req_q.pos_y),
    .tb_i     (tb_q),
    .hit_o    (hu_hit),
    .flags_o  (hu_flags),
    .canvas_o (hu_canvas),
    .cx_o     (hu_cx),
    .cy_o     (hu_cy)
  );

  logic [11:0] rs_w, rs_h;
  logic signed [17:0] sum_w, sum_h;
  always_comb begin
    sum_w = 18'(width_mem[fslot_q]) + 18'(signed'(req_q.pos_x));
    sum_h = 18'(height_mem[fslot_q]) + 18'(signed'(req_q.pos_y));
    rs_w = (sum_w < 1) ? 12'd1 : (sum_w > 18'(SizeMax)) ? SizeMax : sum_w[11:0];
    rs_h = (sum_h < 1) ? 12'd1 : (sum_h > 18'(SizeMax)) ? SizeMax : sum_h[11:0];
  end

  logic [IdxW-1:0] wr_slot;
  assign wr_slot = count_q[IdxW-1:0];
  logic walk_end;
  assign walk_end = (req_q.action == ActClick) ? (pos_q == '0) : (pos_q == count_q);

  // focus after the current item
  always_comb begin
    focus_d = focus_q;
    if (req_q.action == ActCreate && count_q != CntW'(MAX_WINDOWS)) focus_d = {1'b0, newid_q};
    if (req_q.action == ActFocus && found_q && fpos_q + 1 != count_q)
      focus_d = {1'b0, req_q.window_id};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (s_axis_tvalid && s_axis_tready) state_d = StScan;
      StScan: begin
        if (walk_end || (req_q.action == ActClick && hu_hit) ||
            (req_q.action != ActCreate && req_q.action != ActClick &&
             ident_mem[walk_slot] == req_q.window_id)) begin
          if (req_q.action == ActFocus && !walk_end) state_d = StShift;
          else state_d = StDone;
        end
      end
      StShift: if (pos_q + 1 >= count_q) state_d = StDone;
      StDone:  state_d = StOut;
      StOut:   if (!out_valid_q || m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // result word under construction
  always_comb begin
    res_d = res_q;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          res_d          = '0;
          res_d.hit_id   = 5'h1F;
          res_d.canvas_x = 13'h1FFF;
          res_d.canvas_y = 13'h1FFF;
        end
      end
      StScan: begin
        if (req_q.action == ActClick && !walk_end && hu_hit) begin
          res_d.hit_id = {1'b0, ident_mem[walk_slot]};
          {res_d.on_title_bar, res_d.on_top_edge, res_d.on_bottom_edge,
           res_d.on_left_edge, res_d.on_right_edge} = hu_flags;
          if (hu_canvas) begin
            res_d.canvas_x = hu_cx;
            res_d.canvas_y = hu_cy;
          end
        end
      end
      StDone: begin
        res_d.focused_id = focus_d;
        unique case (req_q.action)
          ActCreate: begin
            if (count_q == CntW'(MAX_WINDOWS)) res_d.status = StFull;
            else res_d.hit_id = {1'b0, newid_q};
          end
          ActFocus:  if (!found_q) res_d.status = StNotFound;
          ActMove:   if (!found_q) res_d.status = StNotFound;
          ActResize: if (!found_q) res_d.status = StNotFound;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      focus_q     <= 5'h1F;
      tb_q        <= TitleResetVal;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) tb_q <= cfg_data_i;
      // output register, loaded once the previous word has left
      if (state_q == StOut && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
        out_q       <= res_q;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == StDone) begin
        focus_q <= focus_d;
        if (req_q.action == ActCreate && count_q != CntW'(MAX_WINDOWS))
          count_q <= count_q + 1'b1;
      end
    end
  end

  // datapath and table writes
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          req_q   <= in_req;
          newid_q <= '0;
          found_q <= 1'b0;
          pos_q   <= (in_req.action == ActClick) ? count_q : '0;
        end
      end
      StScan: begin
        if (req_q.action == ActClick) begin
          if (!walk_end && !hu_hit) pos_q <= pos_q - 1'b1;
        end else if (!walk_end) begin
          if (req_q.action == ActCreate) begin
            if (ident_mem[walk_slot] == newid_q) newid_q <= newid_q + 1'b1;
            pos_q <= pos_q + 1'b1;
          end else if (ident_mem[walk_slot] == req_q.window_id) begin
            found_q <= 1'b1;
            fpos_q  <= pos_q;
            fslot_q <= walk_slot;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
      end
      StShift: begin
        if (pos_q + 1 < count_q)
          order_mem[pos_q[IdxW-1:0]] <= order_mem[IdxW'(pos_q + 1)];
        else order_mem[pos_q[IdxW-1:0]] <= fslot_q;
        pos_q <= pos_q + 1'b1;
      end
      StDone: begin
        unique case (req_q.action)
          ActCreate: begin
            if (count_q != CntW'(MAX_WINDOWS)) begin
              ident_mem[wr_slot]  <= newid_q;
              left_mem[wr_slot]   <= COORD_BITS'(signed'(req_q.pos_x));
              top_mem[wr_slot]    <= COORD_BITS'(signed'(req_q.pos_y));
              width_mem[wr_slot]  <= (req_q.size_w == 0) ? 12'd1 : req_q.size_w;
              height_mem[wr_slot] <= (req_q.size_h == 0) ? 12'd1 : req_q.size_h;
              order_mem[wr_slot]  <= wr_slot;
            end
          end
          ActMove: begin
            if (found_q) begin
              left_mem[fslot_q] <= left_mem[fslot_q] + COORD_BITS'(signed'(req_q.pos_x));
              top_mem[fslot_q]  <= top_mem[fslot_q] + COORD_BITS'(signed'(req_q.pos_y));
            end
          end
          ActResize: begin
            if (found_q) begin
              width_mem[fslot_q]  <= rs_w;
              height_mem[fslot_q] <= rs_h;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_WINDOWS)) else $error("window count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_axis_tready) else $error("ready while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && (!m_axis_tvalid || m_axis_tready)) |=> m_axis_tvalid)
    else $error("result lost");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while waiting");
`endif

endmodule
`default_nettype wire

### test/tb_window_stack_hit_test.sv
`timescale 1ns / 100ps
module tb_window_stack_hit_test;
  import wsht_pkg::*;

  localparam int NumWin = 16;

  typedef struct packed {
    logic [4:0]  focused_id;
    logic [12:0] canvas_y;
    logic [12:0] canvas_x;
    logic        on_right_edge;
    logic        on_left_edge;
    logic        on_bottom_edge;
    logic        on_top_edge;
    logic        on_title_bar;
    logic [4:0]  hit_id;
    logic [1:0]  status;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  window_stack_hit_test dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // shadow window table
  logic [3:0]  sh_ident [NumWin];
  int          sh_left  [NumWin];
  int          sh_top   [NumWin];
  int          sh_width [NumWin];
  int          sh_height[NumWin];
  int          sh_order [NumWin];
  int          sh_count;
  int          sh_focus;
  int          sh_title;

  request_t    pending_words[$];
  answer_t     expected_answers[$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_send;

  function automatic int wrap16(int v);
    return int'(signed'(v[15:0]));
  endfunction

  function automatic int clamp_size(int v);
    if (v < 1) return 1;
    if (v > 4095) return 4095;
    return v;
  endfunction

  function automatic int lowest_pos(logic [3:0] id);
    for (int p = 0; p < sh_count; p++)
      if (sh_ident[sh_order[p]] == id) return p;
    return -1;
  endfunction

  // predict one answer and update the shadow table
  function automatic answer_t window_stack_step(request_t rq);
    answer_t a;
    int px, py, hit, cx, cy, pos, s, l, t, w, h, dx, dy, tb;
    logic [3:0] id;
    bit canvas;
    a = '0;
    px = int'(signed'(rq.pos_x));
    py = int'(signed'(rq.pos_y));
    tb = sh_title;
    hit = -1; cx = -1; cy = -1;
    case (rq.action)
      ActCreate: begin
        if (sh_count >= NumWin) begin
          a.status = StFull;
        end else begin
          id = 0;
          for (int p = 0; p < sh_count; p++)
            if (sh_ident[sh_order[p]] == id) id++;
          s = sh_count;
          sh_ident[s] = id;
          sh_left[s] = px;
          sh_top[s] = py;
          sh_width[s] = clamp_size(int'(rq.size_w));
          sh_height[s] = clamp_size(int'(rq.size_h));
          sh_order[s] = s;
          sh_count++;
          sh_focus = int'(id);
          hit = int'(id);
        end
      end
      ActFocus, ActMove, ActResize: begin
        pos = lowest_pos(rq.window_id);
        if (pos < 0) begin
          a.status = StNotFound;
        end else begin
          s = sh_order[pos];
          if (rq.action == ActFocus) begin
            if (pos + 1 != sh_count) begin
              for (int p = pos; p + 1 < sh_count; p++) sh_order[p] = sh_order[p + 1];
              sh_order[sh_count - 1] = s;
              sh_focus = int'(rq.window_id);
            end
          end else if (rq.action == ActMove) begin
            sh_left[s] = wrap16(sh_left[s] + px);
            sh_top[s] = wrap16(sh_top[s] + py);
          end else begin
            sh_width[s] = clamp_size(sh_width[s] + px);
            sh_height[s] = clamp_size(sh_height[s] + py);
          end
        end
      end
      ActClick: begin
        for (int p = sh_count - 1; p >= 0; p--) begin
          s = sh_order[p];
          l = sh_left[s]; t = sh_top[s]; w = sh_width[s]; h = sh_height[s];
          if (!(px >= l && px < l + w + 2 && py >= t && py < t + h + 1 + tb)) continue;
          dx = px - l;
          dy = py - t;
          hit = int'(sh_ident[s]);
          canvas = 1'b1;
          if (dy < tb && dy > 0 && dx > 0 && dx < w) begin
            canvas = 1'b0; a.on_title_bar = 1'b1;
          end
          if (dy == 0) begin
            canvas = 1'b0; a.on_top_edge = 1'b1;
          end else if (dy == h + tb) begin
            canvas = 1'b0; a.on_bottom_edge = 1'b1;
          end
          if (dx == 0) begin
            canvas = 1'b0; a.on_left_edge = 1'b1;
          end else if (dx == w + 1) begin
            canvas = 1'b0; a.on_right_edge = 1'b1;
          end
          if (canvas) begin
            cx = dx - 1; cy = dy - tb;
          end
          break;
        end
      end
      default: ;
    endcase
    a.hit_id = hit[4:0];
    a.canvas_x = cx[12:0];
    a.canvas_y = cy[12:0];
    a.focused_id = sh_focus[4:0];
    return a;
  endfunction

  // driver: predicts at acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_answers.push_back(window_stack_step(request_t'(s_axis_tdata[62:0])));
        void'(pending_words.pop_front());
      end
      if ((!s_axis_tvalid || s_axis_tready) || !s_axis_tvalid) begin
        if (s_axis_tvalid && !s_axis_tready) begin
          // hold current word
        end else if (pending_words.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0) &&
                     !hold_send && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, pending_words[0]};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    answer_t got, exp_a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = answer_t'(m_axis_tdata[42:0]);
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        exp_a = expected_answers.pop_front();
        if (got !== exp_a) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", exp_a, got);
        end
      end
    end
  end

  function automatic request_t make_req(logic [2:0] act, logic [3:0] id, int x, int y,
                                        int w, int h);
    request_t r;
    r.action = act; r.window_id = id;
    r.pos_x = x[15:0]; r.pos_y = y[15:0];
    r.size_w = w[11:0]; r.size_h = h[11:0];
    return r;
  endfunction

  // send everything queued, then pause the sender until every answer is back
  task automatic drain();
    while (pending_words.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    hold_send = 1'b1;
    while (expected_answers.size() != 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    hold_send = 1'b0;
  endtask

  task automatic write_title(logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sh_title = int'(v);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly clicks near existing windows, plus creates, edits and noise words
  function automatic request_t random_req();
    int k, s, x, y;
    k = $urandom_range(99);
    if (k < 15 || sh_count == 0)
      return make_req(ActCreate, 0, $urandom_range(400) - 200, $urandom_range(400) - 200,
                      $urandom_range(k < 3 ? 4095 : 60), $urandom_range(k < 3 ? 4095 : 60));
    if (k < 90 && sh_count > 0) begin
      s = $urandom_range(sh_count - 1);
      x = sh_left[s] + $urandom_range(sh_width[s] + 4) - 1;
      y = sh_top[s] + $urandom_range(sh_height[s] + sh_title + 3) - 1;
      if (k < 60) return make_req(ActClick, 0, x, y, $urandom, $urandom);
      if (k < 70) return make_req(ActFocus, 4'($urandom_range(sh_count)), 0, 0, 0, 0);
      if (k < 80) return make_req(ActMove, 4'($urandom_range(sh_count)),
                                  $urandom_range(40) - 20, $urandom_range(40) - 20, 0, 0);
      return make_req(ActResize, 4'($urandom_range(sh_count)),
                      $urandom_range(40) - 25, $urandom_range(40) - 25, 0, 0);
    end
    // noise: full-range fields, any action code
    return make_req(3'($urandom_range(7)), 4'($urandom), $urandom, $urandom, $urandom,
                    $urandom);
  endfunction

  initial begin
    int sent;
    mismatches = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_send = 1'b0;
    sh_count = 0; sh_focus = -1; sh_title = int'(TitleResetVal);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every action, special cases
    pending_words.push_back(make_req(ActClick, 0, 0, 0, 0, 0));        // empty table
    pending_words.push_back(make_req(ActFocus, 3, 0, 0, 0, 0));        // unknown id
    pending_words.push_back(make_req(ActCreate, 0, 10, 10, 0, 0));     // zero size
    pending_words.push_back(make_req(ActCreate, 15, 32767, -32768, 4095, 4095));
    pending_words.push_back(make_req(ActCreate, 0, 5, 5, 20, 20));
    pending_words.push_back(make_req(ActFocus, 2, 0, 0, 0, 0));        // already on top
    pending_words.push_back(make_req(ActFocus, 0, 0, 0, 0, 0));
    pending_words.push_back(make_req(ActMove, 1, 32767, 32767, 0, 0)); // wrap
    pending_words.push_back(make_req(ActResize, 2, -32768, 32767, 0, 0));
    pending_words.push_back(make_req(ActClick, 0, 10, 10, 0, 0));      // corner
    pending_words.push_back(make_req(ActClick, 0, 12, 14, 0, 0));      // right edge
    pending_words.push_back(make_req(ActClick, 0, 6, 6, 0, 0));
    pending_words.push_back(make_req(ActClick, 0, -30000, 30000, 0, 0)); // miss
    pending_words.push_back(make_req(3'd7, 15, -1, -1, 4095, 4095));  // unknown action
    pending_words.push_back(make_req(3'd5, 0, 0, 0, 0, 0));
    drain();
    write_title(8'd0);
    for (int i = 0; i < 15; i++) pending_words.push_back(make_req(ActCreate, 0, i, i, 3, 3));
    pending_words.push_back(make_req(ActCreate, 0, 0, 0, 1, 1));       // table full
    pending_words.push_back(make_req(ActClick, 0, 14, 14, 0, 0));
    pending_words.push_back(make_req(ActClick, 0, 18, 18, 0, 0));      // title-column case
    drain();

    // random phases with differing idling and title heights
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      write_title(ph == 0 ? 8'd255 : ph == 1 ? 8'd1 : 8'($urandom_range(1, 30)));
      // the table is never cleared; creates fill it up over the phase
      for (int i = 0; i < 125; i++) begin
        pending_words.push_back(random_req());
        // shadow only advances at acceptance, so pace generation
        while (pending_words.size() > 0) @(posedge clk_i);
        sent++;
      end
      drain();
    end
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_answers.size() == 0)
      $display("PASS window_stack_hit_test");
    else
      $display("FAIL window_stack_hit_test");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL window_stack_hit_test");
    $finish;
  end

endmodule
